[src/beacon_listener_table_assert.svh]
// Assertion macros for the beacon listener table.
// No dependencies; included by the modules that assert.
`ifndef BEACON_LISTENER_TABLE_ASSERT_SVH
`define BEACON_LISTENER_TABLE_ASSERT_SVH
// Condition must never hold while out of reset.
`define BLT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define BLT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`endif

[src/blt_pkg.sv]
// Shared types and constants for the beacon listener table.
// No dependencies.
package blt_pkg;
    localparam int DEF_MAX_ENTRIES      = 16;
    localparam int DEF_MAX_NAME_LEN     = 63;
    localparam int DEF_MAX_PACKET_BYTES = 256;
    localparam int HDR_BYTES            = 13;
    localparam logic [20:0] AGE_MAX     = 21'h1FFFFF;
    localparam logic [19:0] TIMEOUT_RST = 20'd10000;

    localparam logic       CFG_PROTOCOL = 1'b0;
    localparam logic       CFG_TIMEOUT  = 1'b1;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_EVICT   = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    localparam logic [2:0] V_ADDED   = 3'd0;
    localparam logic [2:0] V_REFRESH = 3'd1;
    localparam logic [2:0] V_SHORT   = 3'd2;
    localparam logic [2:0] V_NONZERO = 3'd3;
    localparam logic [2:0] V_PROTO   = 3'd4;
    localparam logic [2:0] V_LONG    = 3'd5;
    localparam logic [2:0] V_OVERRUN = 3'd6;
    localparam logic [2:0] V_FULL    = 3'd7;

    typedef struct packed {
        logic        is_tick;
        logic [15:0] tick_ms;
        logic [31:0] ip;
        logic [15:0] port;
        logic        ok;
        logic [2:0]  verdict;
        logic [7:0]  eff;
    } t_job;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  verdict;
        logic [3:0]  slot;
        logic [31:0] ip;
        logic [15:0] port;
        logic        last;
    } t_result;
endpackage

[src/blt_fifo.sv]
// Two-entry queue used between front and back and on the result side.
// No dependencies.
module blt_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    input  logic         i_rd,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    logic [W-1:0] r_mem [0:1];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr_ok, rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_ok) r_wp <= !r_wp;
            if (rd_ok) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr_ok) - 2'(rd_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wp] <= i_data;
    end
endmodule

[src/blt_front.sv]
// Front end: assembles packet bytes, checks the header, holds the incoming name.
// Depends on blt_pkg.
module blt_front #(
    parameter int MAX_NAME_LEN     = 63,
    parameter int MAX_PACKET_BYTES = 256,
    parameter int NAW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic            i_req_type,
    input  logic [31:0]     i_sender_ip,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic [15:0]     i_tick_ms,
    input  logic [31:0]     i_protocol_id,
    output blt_pkg::t_job   o_job,
    output logic            o_job_wr,
    input  logic            i_job_full,
    input  logic            i_name_free,
    input  logic [NAW-1:0]  i_name_addr,
    output logic [7:0]      o_name_data
);
    import blt_pkg::*;
    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

    logic [7:0]    r_name_mem [0:MAX_NAME_LEN-1];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_hdr [0:HDR_BYTES-1];
    logic [7:0]    n_hdr [0:HDR_BYTES-1];
    logic          r_fz_found, n_fz_found;
    logic [7:0]    r_fz, n_fz;
    logic          r_hold;
    logic          acc, acc_byte, store, in_hdr, name_wr;
    logic [CW-1:0] name_idx;
    logic [31:0]   word0, word1;
    logic [7:0]    len;
    logic [10:0]   need;
    t_job          job;

    assign full     = i_job_full || r_hold;
    assign acc      = push && !full;
    assign acc_byte = acc && !i_req_type;
    assign store    = r_cnt < CW'(MAX_PACKET_BYTES);
    assign in_hdr   = r_cnt < CW'(HDR_BYTES);
    assign name_idx = r_cnt - CW'(HDR_BYTES);
    assign name_wr  = store && !in_hdr && (name_idx < CW'(MAX_NAME_LEN));

    always_comb begin
        n_hdr = r_hdr;
        if (store && in_hdr) n_hdr[r_cnt[3:0]] = i_data_byte;
        n_cnt      = r_cnt + CW'(store);
        n_fz_found = r_fz_found || (name_wr && i_data_byte == 8'd0);
        n_fz       = (!r_fz_found && name_wr && i_data_byte == 8'd0) ? 8'(name_idx) : r_fz;
    end

    assign word0 = {n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]};
    assign word1 = {n_hdr[4], n_hdr[5], n_hdr[6], n_hdr[7]};
    assign len   = n_hdr[12];
    assign need  = {3'b0, len} + 11'(HDR_BYTES);

    always_comb begin
        job         = '0;
        job.is_tick = i_req_type;
        job.tick_ms = i_tick_ms;
        job.ip      = i_sender_ip;
        job.port    = {n_hdr[10], n_hdr[11]};
        job.eff     = (n_fz_found && n_fz < len) ? n_fz : len;
        job.ok      = 1'b0;
        priority if (n_cnt < CW'(HDR_BYTES)) job.verdict = V_SHORT;
        else if (word0 != 32'd0)             job.verdict = V_NONZERO;
        else if (word1 != i_protocol_id)     job.verdict = V_PROTO;
        else if (len > 8'(MAX_NAME_LEN))     job.verdict = V_LONG;
        else if (need > 11'(n_cnt))          job.verdict = V_OVERRUN;
        else begin
            job.verdict = V_ADDED;
            job.ok      = 1'b1;
        end
    end

    assign o_job    = job;
    assign o_job_wr = acc && (i_req_type || i_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_fz_found <= 1'b0;
            r_fz       <= '0;
            r_hold     <= 1'b0;
            for (int k = 0; k < HDR_BYTES; k++) r_hdr[k] <= '0;
        end else begin
            if (i_name_free) r_hold <= 1'b0;
            if (acc_byte) begin
                if (i_last_byte) begin
                    // packet done: restart assembly, hold bytes while the name is in use
                    r_cnt      <= '0;
                    r_fz_found <= 1'b0;
                    for (int k = 0; k < HDR_BYTES; k++) r_hdr[k] <= '0;
                    if (job.ok) r_hold <= 1'b1;
                end else begin
                    r_cnt      <= n_cnt;
                    r_fz_found <= n_fz_found;
                    r_fz       <= n_fz;
                    r_hdr      <= n_hdr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_byte && name_wr) r_name_mem[NAW'(name_idx)] <= i_data_byte;
        o_name_data <= r_name_mem[i_name_addr];
    end
endmodule

[src/blt_back.sv]
// Back end: table search, insert and tick aging with eviction.
// Depends on blt_pkg and beacon_listener_table_assert.svh.
module blt_back #(
    parameter int MAX_ENTRIES  = 16,
    parameter int MAX_NAME_LEN = 63,
    parameter int NAW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  blt_pkg::t_job    i_job,
    input  logic             i_job_empty,
    output logic             o_job_rd,
    output logic [NAW-1:0]   o_name_addr,
    input  logic [7:0]       i_name_data,
    output logic             o_name_free,
    input  logic [19:0]      i_timeout_ms,
    output blt_pkg::t_result o_res,
    output logic             o_res_wr,
    input  logic             i_res_full
);
    import blt_pkg::*;
    `include "beacon_listener_table_assert.svh"

    localparam int NS  = MAX_NAME_LEN + 1;
    localparam int JW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SMD = MAX_ENTRIES * NS;
    localparam int SMW = $clog2(SMD);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CK   = 3'd3;
    localparam logic [2:0] S_CRD  = 3'd4;
    localparam logic [2:0] S_CWR  = 3'd5;
    localparam logic [2:0] S_TICK = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [7:0]    r_name_mem [0:SMD-1];
    logic [7:0]    r_slot_byte;
    logic          r_valid [0:MAX_ENTRIES-1];
    logic [31:0]   r_ip    [0:MAX_ENTRIES-1];
    logic [15:0]   r_port  [0:MAX_ENTRIES-1];
    logic [7:0]    r_len   [0:MAX_ENTRIES-1];
    logic [20:0]   r_age   [0:MAX_ENTRIES-1];

    logic [2:0]    r_state;
    t_job          r_job;
    logic [JW-1:0] r_j;
    logic [IW-1:0] r_free;
    logic          r_free_ok;
    logic [7:0]    r_i;
    t_result       r_res;

    logic [IW-1:0] jx;
    logic          meta_hit, last_i, evict;
    logic [21:0]   age_sum;
    logic [20:0]   age_sat;
    logic [SMW-1:0] rd_addr, wr_addr;
    t_result       ev_res;

    assign jx       = IW'(r_j);
    assign meta_hit = r_ip[jx] == r_job.ip && r_port[jx] == r_job.port && r_len[jx] == r_job.eff;
    assign last_i   = (r_i == r_job.eff - 8'd1);
    assign age_sum  = {1'b0, r_age[jx]} + {6'b0, r_job.tick_ms};
    assign age_sat  = age_sum[21] ? AGE_MAX : age_sum[20:0];
    assign evict    = age_sat > {1'b0, i_timeout_ms};
    assign rd_addr  = SMW'(int'(jx) * NS + int'(r_i));
    assign wr_addr  = SMW'(int'(r_free) * NS + int'(r_i));
    assign o_name_addr = NAW'(r_i);

    always_comb begin
        ev_res         = '0;
        ev_res.kind    = KIND_EVICT;
        ev_res.slot    = 4'(r_j);
        ev_res.ip      = r_ip[jx];
        ev_res.port    = r_port[jx];
    end

    assign o_job_rd = (r_state == S_IDLE) && !i_job_empty;
    assign o_res_wr = ((r_state == S_EMIT) && !i_res_full) ||
                      ((r_state == S_TICK) && r_j < JW'(MAX_ENTRIES) && r_valid[jx]
                       && evict && !i_res_full);
    assign o_res    = (r_state == S_EMIT) ? r_res : ev_res;

    always_ff @(posedge i_clk) begin
        o_name_free <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < MAX_ENTRIES; k++) r_valid[k] <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job     <= i_job;
                        r_j       <= '0;
                        r_free_ok <= 1'b0;
                        r_res     <= '0;
                        if (i_job.is_tick) begin
                            r_state <= S_TICK;
                        end else if (!i_job.ok) begin
                            r_res.kind    <= KIND_VERDICT;
                            r_res.verdict <= i_job.verdict;
                            r_res.ip      <= i_job.ip;
                            r_res.port    <= i_job.port;
                            r_res.last    <= 1'b1;
                            r_state       <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_i <= '0;
                    r_res.kind <= KIND_VERDICT;
                    r_res.ip   <= r_job.ip;
                    r_res.port <= r_job.port;
                    r_res.last <= 1'b1;
                    if (r_j == JW'(MAX_ENTRIES)) begin
                        if (!r_free_ok) begin
                            r_res.verdict <= V_FULL;
                            o_name_free   <= 1'b1;
                            r_state       <= S_EMIT;
                        end else if (r_job.eff == 8'd0) begin
                            r_state <= S_CWR;
                        end else begin
                            r_state <= S_CRD;
                        end
                    end else if (r_valid[jx]) begin
                        if (meta_hit && r_job.eff == 8'd0) begin
                            r_age[jx]     <= '0;
                            r_res.verdict <= V_REFRESH;
                            r_res.slot    <= 4'(r_j);
                            o_name_free   <= 1'b1;
                            r_state       <= S_EMIT;
                        end else if (meta_hit) begin
                            r_state <= S_RD;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        if (!r_free_ok) begin
                            r_free    <= jx;
                            r_free_ok <= 1'b1;
                        end
                        r_j <= r_j + 1'b1;
                    end
                end
                S_RD: r_state <= S_CK;
                S_CK: begin
                    if (r_slot_byte != i_name_data) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SCAN;
                    end else if (last_i) begin
                        r_age[jx]     <= '0;
                        r_res.verdict <= V_REFRESH;
                        r_res.slot    <= 4'(r_j);
                        o_name_free   <= 1'b1;
                        r_state       <= S_EMIT;
                    end else begin
                        r_i     <= r_i + 8'd1;
                        r_state <= S_RD;
                    end
                end
                S_CRD: r_state <= S_CWR;
                S_CWR: begin
                    // copy one name byte per pass; commit the entry in the pass that copies the last one
                    if (r_job.eff == 8'd0 || last_i) begin
                        r_valid[r_free] <= 1'b1;
                        r_ip[r_free]    <= r_job.ip;
                        r_port[r_free]  <= r_job.port;
                        r_len[r_free]   <= r_job.eff;
                        r_age[r_free]   <= '0;
                        r_res.verdict   <= V_ADDED;
                        r_res.slot      <= 4'(r_free);
                        o_name_free     <= 1'b1;
                        r_state         <= S_EMIT;
                    end else begin
                        r_i     <= r_i + 8'd1;
                        r_state <= S_CRD;
                    end
                end
                S_TICK: begin
                    if (r_j == JW'(MAX_ENTRIES)) begin
                        r_res.kind <= KIND_TICK;
                        r_res.last <= 1'b1;
                        r_state    <= S_EMIT;
                    end else if (!r_valid[jx]) begin
                        r_j <= r_j + 1'b1;
                    end else if (!(evict && i_res_full)) begin
                        r_age[jx] <= age_sat;
                        if (evict) r_valid[jx] <= 1'b0;
                        r_j <= r_j + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_byte <= r_name_mem[rd_addr];
        if (r_state == S_CWR && r_job.eff != 8'd0) r_name_mem[wr_addr] <= i_name_data;
    end

    `BLT_ASSERT_NEVER(a_res_overflow, i_clk, i_rst_n, o_res_wr && i_res_full, "result written while full")
    `BLT_ASSERT_IMPL(a_ck_after_rd, i_clk, i_rst_n, r_state == S_CK, $past(r_state) == S_RD, "compare without read")
    `BLT_ASSERT_IMPL(a_copy_has_slot, i_clk, i_rst_n, r_state == S_CWR, r_free_ok, "copy without free slot")
    `BLT_ASSERT_IMPL(a_free_on_emit, i_clk, i_rst_n, o_name_free, r_state == S_EMIT && $past(r_state) != S_EMIT, "name release outside verdict")
endmodule

[src/beacon_listener_table.sv]
// Beacon listener table: accepts beacon bytes and ticks; reports verdicts, evictions, tick ends.
// Bytes after a valid packet wait until its search is done. A rejected packet's verdict
// is queued without a table search; an accepted one's follows a search that compares the
// name byte by byte, a read then a compare state per byte, against the slot name memory.
// A tick walks one slot per cycle, waiting on an eviction while the result queue is full.
// Synchronous active-low reset clears the table valid bits and queues, config to defaults.
module beacon_listener_table
    import blt_pkg::*;
#(
    parameter int MAX_ENTRIES      = blt_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_NAME_LEN     = blt_pkg::DEF_MAX_NAME_LEN,
    parameter int MAX_PACKET_BYTES = blt_pkg::DEF_MAX_PACKET_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [31:0] i_sender_ip,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_tick_ms,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_verdict,
    output logic [3:0]  o_slot_index,
    output logic [31:0] o_entry_ip,
    output logic [15:0] o_entry_port,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int NAW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

    logic [31:0]    r_protocol_id;
    logic [19:0]    r_timeout_ms;
    t_job           fr_job, bk_job;
    logic           job_wr, job_rd, job_full, job_empty;
    logic           name_free;
    logic [NAW-1:0] name_addr;
    logic [7:0]     name_data;
    t_result        bk_res, out_res;
    logic           res_wr, res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol_id <= '0;
            r_timeout_ms  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROTOCOL: r_protocol_id <= i_cfg_data;
                CFG_TIMEOUT:  r_timeout_ms  <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    blt_front #(
        .MAX_NAME_LEN(MAX_NAME_LEN), .MAX_PACKET_BYTES(MAX_PACKET_BYTES), .NAW(NAW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_req_type(i_req_type), .i_sender_ip(i_sender_ip), .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte), .i_tick_ms(i_tick_ms), .i_protocol_id(r_protocol_id),
        .o_job(fr_job), .o_job_wr(job_wr), .i_job_full(job_full),
        .i_name_free(name_free), .i_name_addr(name_addr), .o_name_data(name_data)
    );

    blt_fifo #(.W($bits(t_job))) u_job_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(job_wr), .i_data(fr_job),
        .i_rd(job_rd), .o_data(bk_job), .o_full(job_full), .o_empty(job_empty)
    );

    blt_back #(
        .MAX_ENTRIES(MAX_ENTRIES), .MAX_NAME_LEN(MAX_NAME_LEN), .NAW(NAW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(bk_job), .i_job_empty(job_empty),
        .o_job_rd(job_rd), .o_name_addr(name_addr), .i_name_data(name_data),
        .o_name_free(name_free), .i_timeout_ms(r_timeout_ms),
        .o_res(bk_res), .o_res_wr(res_wr), .i_res_full(res_full)
    );

    blt_fifo #(.W($bits(t_result))) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(res_wr), .i_data(bk_res),
        .i_rd(pop), .o_data(out_res), .o_full(res_full), .o_empty(empty)
    );

    assign o_result_kind = out_res.kind;
    assign o_verdict     = out_res.verdict;
    assign o_slot_index  = out_res.slot;
    assign o_entry_ip    = out_res.ip;
    assign o_entry_port  = out_res.port;
    assign o_last_result = out_res.last;
endmodule
